// File: sv/combined_lcg_random_generator_unit_assert.svh
// Assertion macros for the combined LCG random generator unit.
`ifndef COMBINED_LCG_RANDOM_GENERATOR_UNIT_ASSERT_SVH
`define COMBINED_LCG_RANDOM_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CLRG_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("clrg check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define CLRG_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("clrg check failed");

`endif

// File: sv/clrg_pkg.sv
// Package: constants, codes and sequencer states of the combined LCG generator.
package clrg_pkg;

  localparam int unsigned LANES = 3;

  localparam logic [7:0]  MUL_X = 8'd171;
  localparam logic [7:0]  MUL_Y = 8'd172;
  localparam logic [7:0]  MUL_Z = 8'd170;
  localparam logic [14:0] MOD_X = 15'd30269;
  localparam logic [14:0] MOD_Y = 15'd30307;
  localparam logic [14:0] MOD_Z = 15'd30323;

  localparam logic [14:0] RST_X = 15'd18721;
  localparam logic [15:0] RST_Y = 16'd37264;
  localparam logic [14:0] RST_Z = 15'd28737;

  // Reciprocals: floor(mul * 2^16 / mod) for an advance, floor(2^32 / mod) for a digit.
  localparam int unsigned RCP_SHIFT = 16;
  localparam logic [17:0] RCP_MUL_X = 18'((64'd171 << RCP_SHIFT) / 64'd30269);
  localparam logic [17:0] RCP_MUL_Y = 18'((64'd172 << RCP_SHIFT) / 64'd30307);
  localparam logic [17:0] RCP_MUL_Z = 18'((64'd170 << RCP_SHIFT) / 64'd30323);
  localparam logic [17:0] RCP_DIG_X = 18'((64'd1 << 32) / 64'd30269);
  localparam logic [17:0] RCP_DIG_Y = 18'((64'd1 << 32) / 64'd30307);
  localparam logic [17:0] RCP_DIG_Z = 18'((64'd1 << 32) / 64'd30323);

  localparam logic [7:0]  LANE_MUL     [LANES] = '{MUL_X, MUL_Y, MUL_Z};
  localparam logic [14:0] LANE_MOD     [LANES] = '{MOD_X, MOD_Y, MOD_Z};
  localparam logic [17:0] LANE_RCP_MUL [LANES] = '{RCP_MUL_X, RCP_MUL_Y, RCP_MUL_Z};
  localparam logic [17:0] LANE_RCP_DIG [LANES] = '{RCP_DIG_X, RCP_DIG_Y, RCP_DIG_Z};

  // Gaussian scaling: floor(S * 3 * 2^16 / 90899) - 6 * 2^16.
  localparam int unsigned G_SHIFT = 19;
  localparam logic [16:0] G_DEN   = 17'd90899;
  localparam logic [20:0] G_RCP   = 21'((64'd196608 << G_SHIFT) / 64'd90899);
  localparam logic [19:0] G_OFS   = 20'd393216;

  typedef enum logic [1:0] {
    FN_UNIFORM,
    FN_INTEGER,
    FN_GAUSS,
    FN_LOAD
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADV_MUL,
    ST_ADV_RED,
    ST_HI_MUL,
    ST_HI_RED,
    ST_LO_MUL,
    ST_LO_RED,
    ST_G_SUM,
    ST_G_MUL,
    ST_G_RED,
    ST_FIN
  } seq_state_t;

endpackage

// File: sv/combined_lcg_random_generator_unit.sv
// Wichmann-Hill combined generator: three MCG streams, uniform, integer, gaussian, load.
//
// One command is taken at a time; cmd_stall stays high until its result sits in the
// output register. Every advance and every 16-bit quotient digit runs through one
// shared three-lane multiply-and-reduce unit (reciprocal estimate, then remainder with
// one correction). A load only sets the streams; integer takes one advance, uniform one
// advance plus two digits per stream, gaussian four chained advances, a final sum and a
// scaling.
module combined_lcg_random_generator_unit
  import clrg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  logic [1:0]         func,
  input  logic [14:0]        load_x,
  input  logic [14:0]        load_y,
  input  logic [14:0]        load_z,
  output logic               res_valid,
  input  logic               res_stall,
  output logic [31:0]        uniform_fraction,
  output logic [14:0]        integer_value,
  output logic signed [19:0] gauss_value,
  output logic [14:0]        state_x,
  output logic [14:0]        state_y,
  output logic [14:0]        state_z
);

  seq_state_t  state, state_next;
  func_t       op;
  logic [1:0]  adv_cnt;
  logic [14:0] stream_x;
  logic [15:0] stream_y;
  logic [14:0] stream_z;

  logic [15:0] opnd [LANES];
  logic [31:0] prod [LANES];
  logic [15:0] quot [LANES];
  logic [15:0] hi   [LANES];
  logic [15:0] lo   [LANES];

  logic [18:0] gsum;
  logic [36:0] gprod;
  logic [19:0] gest;
  logic [19:0] gres;

  logic        cmd_take;
  logic        fin_go;
  logic        digit;

  logic [17:0] rcp_sel  [LANES];
  logic [33:0] est_full [LANES];
  logic [31:0] p_next   [LANES];
  logic [15:0] q_next   [LANES];
  logic [30:0] red_qm   [LANES];
  logic [31:0] red_diff [LANES];
  logic        red_fix  [LANES];
  logic [15:0] red_rem  [LANES];
  logic [15:0] red_quot [LANES];

  logic [18:0] lane_sum;
  logic [39:0] g_est_full;
  logic [36:0] g_qm;
  logic [36:0] g_diff;
  logic [19:0] g_quot;
  logic [31:0] usum;

  logic        streams_ok;
  logic        digits_ok;
  logic        gauss_ok;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_stall  = (state != ST_IDLE);
    cmd_take   = 1'b0;
    fin_go     = 1'b0;
    digit      = 1'b0;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_take   = 1'b1;
          state_next = (func_t'(func) == FN_LOAD) ? ST_FIN : ST_ADV_MUL;
        end
      end
      ST_ADV_MUL: state_next = ST_ADV_RED;
      ST_ADV_RED: begin
        case (op)
          FN_UNIFORM: state_next = ST_HI_MUL;
          FN_GAUSS:   state_next = (adv_cnt == 2'd3) ? ST_G_SUM : ST_ADV_MUL;
          default:    state_next = ST_FIN;
        endcase
      end
      ST_HI_MUL: begin
        digit      = 1'b1;
        state_next = ST_HI_RED;
      end
      ST_HI_RED: state_next = ST_LO_MUL;
      ST_LO_MUL: begin
        digit      = 1'b1;
        state_next = ST_LO_RED;
      end
      ST_LO_RED: state_next = ST_FIN;
      ST_G_SUM:  state_next = ST_G_MUL;
      ST_G_MUL:  state_next = ST_G_RED;
      ST_G_RED:  state_next = ST_FIN;
      ST_FIN: begin
        if (!res_valid || !res_stall) begin
          fin_go     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Shared multiply-and-reduce unit, one lane per stream
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      rcp_sel[i]  = digit ? LANE_RCP_DIG[i] : LANE_RCP_MUL[i];
      est_full[i] = opnd[i] * rcp_sel[i];
      q_next[i]   = est_full[i][RCP_SHIFT +: 16];
      p_next[i]   = digit ? {opnd[i], 16'b0} : 32'(opnd[i] * LANE_MUL[i]);
      red_qm[i]   = quot[i] * LANE_MOD[i];
      red_diff[i] = prod[i] - {1'b0, red_qm[i]};
      red_fix[i]  = (red_diff[i] >= {17'b0, LANE_MOD[i]});
      red_rem[i]  = red_fix[i] ? 16'(red_diff[i] - {17'b0, LANE_MOD[i]}) : red_diff[i][15:0];
      red_quot[i] = quot[i] + {15'b0, red_fix[i]};
    end
  end

  assign lane_sum = {3'b0, opnd[0]} + {3'b0, opnd[1]} + {3'b0, opnd[2]};

  // Gaussian scaling
  assign g_est_full = gsum * G_RCP;
  assign g_qm       = gest * G_DEN;
  assign g_diff     = gprod - g_qm;
  assign g_quot     = gest + {19'b0, (g_diff >= {20'b0, G_DEN})};

  assign usum = {hi[0], lo[0]} + {hi[1], lo[1]} + {hi[2], lo[2]};

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      stream_x  <= RST_X;
      stream_y  <= RST_Y;
      stream_z  <= RST_Z;
      adv_cnt   <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cmd_take) begin
        adv_cnt <= '0;
        if (func_t'(func) == FN_LOAD) begin
          stream_x <= load_x;
          stream_y <= {1'b0, load_y};
          stream_z <= load_z;
        end
      end
      if (state == ST_ADV_RED) begin
        stream_x <= red_rem[0][14:0];
        stream_y <= red_rem[1];
        stream_z <= red_rem[2][14:0];
        adv_cnt  <= adv_cnt + 2'd1;
      end
      if (fin_go) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      op      <= func_t'(func);
      opnd[0] <= {1'b0, stream_x};
      opnd[1] <= stream_y;
      opnd[2] <= {1'b0, stream_z};
      gsum    <= '0;
    end
    case (state)
      ST_ADV_MUL, ST_HI_MUL, ST_LO_MUL: begin
        for (int i = 0; i < LANES; i++) begin
          prod[i] <= p_next[i];
          quot[i] <= q_next[i];
        end
        if (state == ST_ADV_MUL && op == FN_GAUSS && adv_cnt != 2'd0) begin
          gsum <= gsum + lane_sum;
        end
      end
      ST_ADV_RED: begin
        for (int i = 0; i < LANES; i++) begin
          opnd[i] <= red_rem[i];
        end
      end
      ST_HI_RED: begin
        for (int i = 0; i < LANES; i++) begin
          opnd[i] <= red_rem[i];
          hi[i]   <= red_quot[i];
        end
      end
      ST_LO_RED: begin
        for (int i = 0; i < LANES; i++) begin
          lo[i] <= red_quot[i];
        end
      end
      ST_G_SUM: gsum <= gsum + lane_sum;
      ST_G_MUL: begin
        gprod <= {(21'(gsum) + {gsum, 1'b0}), 16'b0};
        gest  <= g_est_full[G_SHIFT +: 20];
      end
      ST_G_RED: gres <= g_quot - G_OFS;
      default: ;
    endcase
    if (fin_go) begin
      uniform_fraction <= (op == FN_UNIFORM) ? usum : '0;
      integer_value    <= (op == FN_INTEGER) ? stream_z : '0;
      gauss_value      <= (op == FN_GAUSS) ? signed'(gres) : '0;
      state_x          <= stream_x;
      state_y          <= stream_y[14:0];
      state_z          <= stream_z;
    end
  end

  assign streams_ok = (stream_x < MOD_X) && (stream_y < {1'b0, MOD_Y}) &&
                      (stream_z < MOD_Z);
  assign digits_ok  = (red_rem[0] < {1'b0, MOD_X}) && (red_rem[1] < {1'b0, MOD_Y}) &&
                      (red_rem[2] < {1'b0, MOD_Z});
  assign gauss_ok   = (gauss_value >= -20'sd393216) && (gauss_value <= 20'sd393215);

  `include "combined_lcg_random_generator_unit_assert.svh"

  `CLRG_ASSERT_NEXT(a_busy_after_transfer, cmd_valid && !cmd_stall, cmd_stall)
  `CLRG_ASSERT_NEXT(a_stream_reduced, state == ST_ADV_RED, streams_ok)
  `CLRG_ASSERT_NOW(a_digit_rem, state == ST_HI_RED || state == ST_LO_RED, digits_ok)
  `CLRG_ASSERT_NEXT(a_result_loaded, fin_go, res_valid && !cmd_stall)
  `CLRG_ASSERT_NOW(a_gauss_range, res_valid, gauss_ok)

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the combined LCG generator: directed corners, random mix.
module tb_top;
  import clrg_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 650;
  localparam int MAX_WAIT     = 18;
  localparam int TAIL_CYCLES  = 20;

  localparam logic [63:0] GAUSS_NUM = 64'd196608;
  localparam logic [63:0] GAUSS_DEN = 64'd90899;
  localparam logic [63:0] GAUSS_OFS = 64'd393216;

  typedef struct {
    logic [31:0]        uniform;
    logic [14:0]        int_val;
    logic signed [19:0] gauss;
    logic [14:0]        sx;
    logic [14:0]        sy;
    logic [14:0]        sz;
  } draw_t;

  logic               clk;
  logic               rst       = 1'b1;
  logic               cmd_valid = 1'b0;
  logic               cmd_stall;
  logic [1:0]         func      = 2'd0;
  logic [14:0]        load_x    = '0;
  logic [14:0]        load_y    = '0;
  logic [14:0]        load_z    = '0;
  logic               res_valid;
  logic               res_stall = 1'b0;
  logic [31:0]        uniform_fraction;
  logic [14:0]        integer_value;
  logic signed [19:0] gauss_value;
  logic [14:0]        state_x;
  logic [14:0]        state_y;
  logic [14:0]        state_z;

  // predicted generator state, at the block's widths
  logic [14:0] gen_x;
  logic [15:0] gen_y;
  logic [14:0] gen_z;

  draw_t expected_draws[$];
  int    op_count[4];
  int    results_seen = 0;
  int    errors       = 0;
  int    cycles       = 0;
  int    rx_wait      = 0;
  bit    tx_steady    = 1'b0;
  bit    rx_steady    = 1'b0;

  combined_lcg_random_generator_unit u_top (
    .clk              (clk),
    .rst              (rst),
    .cmd_valid        (cmd_valid),
    .cmd_stall        (cmd_stall),
    .func             (func),
    .load_x           (load_x),
    .load_y           (load_y),
    .load_z           (load_z),
    .res_valid        (res_valid),
    .res_stall        (res_stall),
    .uniform_fraction (uniform_fraction),
    .integer_value    (integer_value),
    .gauss_value      (gauss_value),
    .state_x          (state_x),
    .state_y          (state_y),
    .state_z          (state_z)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void advance_streams();
    gen_x = 15'((32'(gen_x) * MUL_X) % MOD_X);
    gen_y = 16'((32'(gen_y) * MUL_Y) % MOD_Y);
    gen_z = 15'((32'(gen_z) * MUL_Z) % MOD_Z);
  endfunction

  function automatic logic [31:0] frac_q32(logic [31:0] v, logic [31:0] modulus);
    return 32'((64'(v) << 32) / 64'(modulus));
  endfunction

  function automatic draw_t predict_draw(func_t op, logic [14:0] lx, logic [14:0] ly,
                                         logic [14:0] lz);
    draw_t       d;
    logic [63:0] sum;
    logic [63:0] scaled;
    d.uniform = '0;
    d.int_val = '0;
    d.gauss   = '0;
    sum       = '0;
    case (op)
      FN_UNIFORM: begin
        advance_streams();
        d.uniform = frac_q32(gen_x, MOD_X) + frac_q32(gen_y, MOD_Y) + frac_q32(gen_z, MOD_Z);
      end
      FN_INTEGER: begin
        advance_streams();
        d.int_val = gen_z;
      end
      FN_GAUSS: begin
        repeat (4) begin
          advance_streams();
          sum = sum + 64'(gen_x) + 64'(gen_y) + 64'(gen_z);
        end
        scaled  = (sum * GAUSS_NUM) / GAUSS_DEN - GAUSS_OFS;
        d.gauss = scaled[19:0];
      end
      default: begin
        gen_x = lx;
        gen_y = {1'b0, ly};
        gen_z = lz;
      end
    endcase
    d.sx = gen_x;
    d.sy = gen_y[14:0];
    d.sz = gen_z;
    return d;
  endfunction

  task automatic send_cmd(func_t op, logic [14:0] lx, logic [14:0] ly, logic [14:0] lz);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap != 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    func      <= op;
    load_x    <= lx;
    load_y    <= ly;
    load_z    <= lz;
    do @(posedge clk); while (cmd_stall);
    expected_draws.push_back(predict_draw(op, lx, ly, lz));
    op_count[op]++;
  endtask

  task automatic send_op(func_t op);
    send_cmd(op, 15'($urandom_range(0, 32767)), 15'($urandom_range(0, 32767)),
             15'($urandom_range(0, 32767)));
  endtask

  // hold the sender off until every outstanding result has been taken
  task automatic drain();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (expected_draws.size() != 0);
  endtask

  function automatic logic [14:0] pick_seed(logic [14:0] modulus);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r <= 2) return 15'($urandom_range(modulus, 32767));
    if (r == 3) return 15'h7fff;
    return 15'($urandom_range(1, modulus - 1));
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    draw_t want;
    if (rst) begin
      res_stall <= 1'b0;
      rx_wait = 0;
    end else begin
      if (res_valid && !res_stall) begin
        if (expected_draws.size() == 0) begin
          $error("result transfer with no command outstanding");
          errors++;
        end else begin
          want = expected_draws.pop_front();
          check_field("uniform_fraction", want.uniform, uniform_fraction);
          check_field("integer_value", 32'(want.int_val), 32'(integer_value));
          check_field("gauss_value", 32'(want.gauss), 32'(gauss_value));
          check_field("state_x", 32'(want.sx), 32'(state_x));
          check_field("state_y", 32'(want.sy), 32'(state_y));
          check_field("state_z", 32'(want.sz), 32'(state_z));
          results_seen++;
        end
        rx_wait = rx_steady ? 0 : $urandom_range(0, MAX_WAIT);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      res_stall <= (rx_wait != 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // first advances see the reset state, stream_y above its modulus
  task automatic test_after_reset();
    send_op(FN_UNIFORM);
    send_op(FN_INTEGER);
    send_op(FN_GAUSS);
    drain();
  endtask

  task automatic test_load_corners();
    send_cmd(FN_LOAD, '0, '0, '0);
    send_op(FN_UNIFORM);
    send_op(FN_GAUSS);
    send_op(FN_INTEGER);
    send_cmd(FN_LOAD, 15'h7fff, 15'h7fff, 15'h7fff);
    send_op(FN_UNIFORM);
    send_cmd(FN_LOAD, MOD_X, MOD_Y, MOD_Z);
    send_op(FN_INTEGER);
    send_cmd(FN_LOAD, MOD_X - 1, MOD_Y - 1, MOD_Z - 1);
    send_op(FN_GAUSS);
    send_cmd(FN_LOAD, 15'h5555, 15'h2aaa, 15'h5555);
    send_op(FN_UNIFORM);
    send_cmd(FN_LOAD, 15'h2aaa, 15'h5555, 15'h2aaa);
    send_op(FN_GAUSS);
    send_cmd(FN_LOAD, 15'd1, 15'd1, 15'd1);
    send_op(FN_UNIFORM);
    send_cmd(FN_LOAD, '0, MOD_Y - 1, 15'd1);
    send_op(FN_INTEGER);
    send_op(FN_GAUSS);
    drain();
  endtask

  task automatic test_random_mix();
    int    r;
    func_t op;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0) begin
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
      end
      if (i % 150 == 149) drain();
      r  = $urandom_range(0, 99);
      op = (r < 12) ? FN_LOAD : func_t'(r % 3);
      if (op == FN_LOAD)
        send_cmd(FN_LOAD, pick_seed(MOD_X), pick_seed(MOD_Y), pick_seed(MOD_Z));
      else
        send_op(op);
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    gen_x = RST_X;
    gen_y = RST_Y;
    gen_z = RST_Z;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_after_reset();
    test_load_corners();
    test_random_mix();
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    errors += expected_draws.size();
    $display("Ran %0d uniform, %0d integer, %0d gaussian and %0d load commands",
             op_count[FN_UNIFORM], op_count[FN_INTEGER], op_count[FN_GAUSS],
             op_count[FN_LOAD]);
    $display("under random stalls on both sides; %0d results compared, %0d errors",
             results_seen, errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
